// File: rtl/core/segment_intersection_defines.svh
// Assertion macros shared by the segment intersection RTL.
// Needs a clk and rst_n in scope where a macro is used.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define SI_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define SI_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/si_pkg.sv
// Shared widths and the divider chain record for segment_intersection.
// No dependencies.
`default_nettype none
package si_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CW    = 32;             // input coordinate width
  localparam int SW    = CW + 1;         // coordinate difference width
  localparam int PW    = 2 * SW;         // cross product width
  localparam int NW    = PW + 1;         // den / sn / tn width
  localparam int MW    = CW;             // difference magnitude width
  localparam int RW    = NW - 1;         // divider remainder width
  localparam int HW    = RW - SW;        // upper slice of tn
  localparam int FW    = MW;             // numerator bits fed into the chain
  localparam int PPW   = RW + FW;        // tn * |s| width
  localparam int QW    = 48;             // result coordinate width
  localparam int NCELL = MW + FRAC_BITS; // quotient bits, one per cell

  typedef struct packed {
    logic                 func;
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  } si_seg_t;

  typedef struct packed {
    logic                 vld;
    logic                 hit;
    logic [RW-1:0]        den;
    logic [RW-1:0]        rx, ry;
    logic [FW-1:0]        fx, fy;
    logic [QW-1:0]        qx, qy;
    logic                 negx, negy;
    logic signed [CW-1:0] ax, ay;
  } si_div_t;
endpackage
`default_nettype wire

// File: rtl/core/si_in_if.sv
// Request channel carrying one pair of segments.
// Depends on si_pkg for the coordinate width.
`default_nettype none
interface si_in_if;
  import si_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  modport source (output valid, func, ax, ay, bx, by, cx, cy, dx, dy, input ready);
  modport sink   (input valid, func, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface
`default_nettype wire

// File: rtl/core/si_out_if.sv
// Result channel carrying the hit flag and the fixed point intersection.
// Depends on si_pkg for the result width.
`default_nettype none
interface si_out_if;
  import si_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [QW-1:0] ix, iy;
  modport source (output valid, hit, ix, iy, input ready);
  modport sink   (input valid, hit, ix, iy, output ready);
endinterface
`default_nettype wire

// File: rtl/core/si_setup.sv
// Front pipeline: differences, cross products, sign fold, hit test and numerator.
// Depends on si_pkg.
`default_nettype none
module si_setup import si_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_vld,
  input  wire si_seg_t in_seg,
  output si_div_t      head
);
  // stage 1: differences
  logic                 v1_r, f1_r;
  logic signed [CW-1:0] ax1_r, ay1_r;
  logic signed [SW-1:0] s1x_r, s1y_r, s2x_r, s2y_r, wx_r, wy_r;
  // stage 2: products
  logic                 v2_r, f2_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  logic signed [SW-1:0] s1x2_r, s1y2_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  // stage 3: den, sn, tn
  logic                 v3_r, f3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  logic signed [SW-1:0] s1x3_r, s1y3_r;
  logic signed [NW-1:0] den3_r, sn3_r, tn3_r;
  // stage 4: sign fold
  logic                 v4_r, f4_r, negx4_r, negy4_r;
  logic signed [CW-1:0] ax4_r, ay4_r;
  logic [MW-1:0]        magx4_r, magy4_r;
  logic signed [NW-1:0] den4_r, sn4_r, tn4_r;
  // stage 5: hit and partial products
  logic                 v5_r, hit5_r, negx5_r, negy5_r;
  logic signed [CW-1:0] ax5_r, ay5_r;
  logic [RW-1:0]        den5_r;
  logic [SW+MW-1:0]     tlx_r, tly_r;
  logic [HW+MW-1:0]     thx_r, thy_r;

  logic signed [SW-1:0] s1x_nxt, s1y_nxt;
  logic signed [NW-1:0] den_nxt, sn_nxt, tn_nxt;
  logic                 neg_den, hit_nxt, excl;
  logic [PPW-1:0]       px, py;
  si_div_t              head_r, head_nxt;

  assign s1x_nxt = {in_seg.bx[CW-1], in_seg.bx} - {in_seg.ax[CW-1], in_seg.ax};
  assign s1y_nxt = {in_seg.by[CW-1], in_seg.by} - {in_seg.ay[CW-1], in_seg.ay};
  assign den_nxt = NW'(p1_r) - NW'(p2_r);
  assign sn_nxt  = NW'(p3_r) - NW'(p4_r);
  assign tn_nxt  = NW'(p5_r) - NW'(p6_r);
  assign neg_den = den3_r[NW-1];

  // inside both segments, then drop endpoint hits in the exclusive mode
  always_comb begin
    hit_nxt = (den4_r != '0) && !sn4_r[NW-1] && !tn4_r[NW-1] &&
              (sn4_r <= den4_r) && (tn4_r <= den4_r);
    excl = f4_r && ((tn4_r == '0) || (tn4_r == den4_r) ||
                    (sn4_r == '0) || (sn4_r == den4_r));
  end

  // join partial products into tn * |s|
  assign px = (PPW'(thx_r) << SW) + PPW'(tlx_r);
  assign py = (PPW'(thy_r) << SW) + PPW'(tly_r);

  always_comb begin
    head_nxt      = '0;
    head_nxt.vld  = v5_r;
    head_nxt.hit  = hit5_r;
    head_nxt.den  = den5_r;
    head_nxt.rx   = px[PPW-1:FW];
    head_nxt.ry   = py[PPW-1:FW];
    head_nxt.fx   = px[FW-1:0];
    head_nxt.fy   = py[FW-1:0];
    head_nxt.negx = negx5_r;
    head_nxt.negy = negy5_r;
    head_nxt.ax   = ax5_r;
    head_nxt.ay   = ay5_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      head_r <= '0;
    end else if (en) begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      head_r <= head_nxt;
    end
  end

  // payload, advance with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= in_seg.func;
      ax1_r  <= in_seg.ax;
      ay1_r  <= in_seg.ay;
      s1x_r  <= s1x_nxt;
      s1y_r  <= s1y_nxt;
      s2x_r  <= {in_seg.dx[CW-1], in_seg.dx} - {in_seg.cx[CW-1], in_seg.cx};
      s2y_r  <= {in_seg.dy[CW-1], in_seg.dy} - {in_seg.cy[CW-1], in_seg.cy};
      wx_r   <= {in_seg.ax[CW-1], in_seg.ax} - {in_seg.cx[CW-1], in_seg.cx};
      wy_r   <= {in_seg.ay[CW-1], in_seg.ay} - {in_seg.cy[CW-1], in_seg.cy};

      f2_r   <= f1_r;  ax2_r <= ax1_r;  ay2_r <= ay1_r;
      s1x2_r <= s1x_r; s1y2_r <= s1y_r;
      p1_r   <= s1x_r * s2y_r;
      p2_r   <= s2x_r * s1y_r;
      p3_r   <= s1x_r * wy_r;
      p4_r   <= s1y_r * wx_r;
      p5_r   <= s2x_r * wy_r;
      p6_r   <= s2y_r * wx_r;

      f3_r   <= f2_r;  ax3_r <= ax2_r;  ay3_r <= ay2_r;
      s1x3_r <= s1x2_r; s1y3_r <= s1y2_r;
      den3_r <= den_nxt; sn3_r <= sn_nxt; tn3_r <= tn_nxt;

      f4_r    <= f3_r; ax4_r <= ax3_r; ay4_r <= ay3_r;
      negx4_r <= s1x3_r[SW-1];
      negy4_r <= s1y3_r[SW-1];
      magx4_r <= s1x3_r[SW-1] ? MW'(-s1x3_r) : MW'(s1x3_r);
      magy4_r <= s1y3_r[SW-1] ? MW'(-s1y3_r) : MW'(s1y3_r);
      den4_r  <= neg_den ? -den3_r : den3_r;
      sn4_r   <= neg_den ? -sn3_r  : sn3_r;
      tn4_r   <= neg_den ? -tn3_r  : tn3_r;

      hit5_r  <= hit_nxt && !excl;
      negx5_r <= negx4_r; negy5_r <= negy4_r;
      ax5_r   <= ax4_r;   ay5_r   <= ay4_r;
      den5_r  <= den4_r[RW-1:0];
      tlx_r   <= tn4_r[SW-1:0] * magx4_r;
      tly_r   <= tn4_r[SW-1:0] * magy4_r;
      thx_r   <= tn4_r[RW-1:SW] * magx4_r;
      thy_r   <= tn4_r[RW-1:SW] * magy4_r;
    end
  end

  assign head = head_r;
endmodule
`default_nettype wire

// File: rtl/core/si_cell.sv
// One restoring division step for both coordinates, one quotient bit each.
// Depends on si_pkg.
`default_nettype none
module si_cell import si_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire si_div_t d_i,
  output si_div_t      d_o
);
  si_div_t       d_r, d_nxt;
  logic [RW-1:0] tx, ty;
  logic          gex, gey;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    tx    = {d_i.rx[RW-2:0], d_i.fx[FW-1]};
    ty    = {d_i.ry[RW-2:0], d_i.fy[FW-1]};
    gex   = tx >= d_i.den;
    gey   = ty >= d_i.den;
    d_nxt = d_i;
    d_nxt.rx = gex ? tx - d_i.den : tx;
    d_nxt.ry = gey ? ty - d_i.den : ty;
    d_nxt.fx = d_i.fx << 1;
    d_nxt.fy = d_i.fy << 1;
    d_nxt.qx = {d_i.qx[QW-2:0], gex};
    d_nxt.qy = {d_i.qy[QW-2:0], gey};
  end

  // hand to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
`default_nettype wire

// File: rtl/core/segment_intersection.sv
// Segment intersection top: setup pipeline, divider cell chain, output register.
// Depends on si_pkg, si_in_if, si_out_if, si_setup, si_cell and the defines header.
//
//   channel  dir  payload                         handshake
//   in_ch    in   func, ax ay bx by cx cy dx dy   valid/ready
//   out_ch   out  hit, ix, iy                     valid/ready
//
// One request enters per cycle unless a result waits; it passes the setup
// pipeline, the chain of one-bit division cells and the output register.
// The whole pipeline advances together; it stops only while a result waits.
// Reset is synchronous; it clears the valid bits, the chain head and every cell.
`default_nettype none
`include "segment_intersection_defines.svh"
module segment_intersection import si_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  si_in_if.sink     in_ch,
  si_out_if.source  out_ch
);
  logic                 en;
  logic                 out_v_r, hit_r;
  logic signed [QW-1:0] ix_r, iy_r;
  logic [QW-1:0]        basex, basey, offx, offy, ix_nxt, iy_nxt;
  si_seg_t              seg;
  si_div_t              chain [NCELL+1];
  si_div_t              tail;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    seg.func = in_ch.func;
    seg.ax = in_ch.ax; seg.ay = in_ch.ay; seg.bx = in_ch.bx; seg.by = in_ch.by;
    seg.cx = in_ch.cx; seg.cy = in_ch.cy; seg.dx = in_ch.dx; seg.dy = in_ch.dy;
  end

  si_setup u_setup (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .in_seg (seg),
    .head   (chain[0])
  );

  // division chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    si_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[i]),
      .d_o   (chain[i+1])
    );
  end

  assign tail = chain[NCELL];

  // floor toward minus infinity: round the offset up when moving down
  always_comb begin
    basex  = QW'(tail.ax) << FRAC_BITS;
    basey  = QW'(tail.ay) << FRAC_BITS;
    offx   = tail.qx + QW'(tail.negx && (tail.rx != '0));
    offy   = tail.qy + QW'(tail.negy && (tail.ry != '0));
    ix_nxt = tail.negx ? basex - offx : basex + offx;
    iy_nxt = tail.negy ? basey - offy : basey + offy;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= tail.hit;
      ix_r  <= tail.hit ? ix_nxt : '0;
      iy_r  <= tail.hit ? iy_nxt : '0;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.hit   = hit_r;
  assign out_ch.ix    = ix_r;
  assign out_ch.iy    = iy_r;

  `SI_CHK_NEXT(a_stall_hold, !en, $stable(chain[1]), "chain moved during stall")
  `SI_CHK_IMPL(a_tail_den, tail.vld && tail.hit, tail.den != '0, "hit with zero denominator")
  `SI_CHK_IMPL(a_miss_zero, out_v_r && !hit_r, ix_r == '0 && iy_r == '0, "miss with nonzero point")
endmodule
`default_nettype wire

// File: tb/segment_intersection_test.sv
// Self-checking testbench for segment_intersection: directed pairs, then random traffic.
// Depends on si_pkg, si_in_if, si_out_if and the segment_intersection RTL.
module segment_intersection_test;
  import si_pkg::*;

  localparam bit FUNC_PLAIN   = 1'b0;
  localparam bit FUNC_NO_ENDS = 1'b1;
  localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
  localparam int N_RANDOM   = 1700;
  localparam int DRAIN_WAIT = 80;
  localparam int CYCLE_CAP  = 2000000;

  typedef struct packed {
    logic                 hit;
    logic signed [QW-1:0] ix, iy;
  } seg_hit_t;

  typedef struct {
    si_seg_t  req;
    bit       known;
    seg_hit_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  si_in_if  in_ch ();
  si_out_if out_ch ();

  seg_hit_t hit_q[$];
  dir_row_t dir_tab[$];
  int       errors;
  int       cycles;
  int       snd_idle_pct;
  int       rcv_idle_pct;
  int       hold_cycles;

  segment_intersection u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10-unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Point base + floor(tn * s / den) in fixed point, den > 0
  function automatic logic signed [QW-1:0] fix_point(logic signed [CW-1:0] base,
      logic signed [39:0] s, logic signed [79:0] tn, logic signed [79:0] den);
    logic signed [159:0] num;
    logic signed [159:0] quo;
    logic signed [159:0] b;
    num = tn * s;
    num = num <<< FRAC_BITS;
    quo = num / den;
    if (num < 0 && quo * den != num) quo = quo - 1;
    b = base;
    b = (b <<< FRAC_BITS) + quo;
    return b[QW-1:0];
  endfunction

  // Exact cross-product intersection test
  function automatic seg_hit_t seg_cross(si_seg_t r);
    logic signed [39:0] s1x, s1y, s2x, s2y, wx, wy;
    logic signed [79:0] den, sn, tn;
    seg_hit_t res;
    res = '0;
    s1x = r.bx - r.ax;
    s1y = r.by - r.ay;
    s2x = r.dx - r.cx;
    s2y = r.dy - r.cy;
    wx  = r.ax - r.cx;
    wy  = r.ay - r.cy;
    den = s1x * s2y - s2x * s1y;
    sn  = s1x * wy - s1y * wx;
    tn  = s2x * wy - s2y * wx;
    if (den == 0) return res;
    if (den < 0) begin
      den = -den;
      sn  = -sn;
      tn  = -tn;
    end
    res.hit = sn >= 0 && tn >= 0 && sn <= den && tn <= den;
    if (res.hit && r.func == FUNC_NO_ENDS &&
        (tn == 0 || tn == den || sn == 0 || sn == den))
      res.hit = 1'b0;
    if (res.hit) begin
      res.ix = fix_point(r.ax, s1x, tn, den);
      res.iy = fix_point(r.ay, s1y, tn, den);
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int kind, logic signed [CW-1:0] org);
    case (kind)
      0: return $signed(32'($urandom_range(12))) - 6;
      1: return org + $signed(32'($urandom_range(2000))) - 1000;
      2: begin
        case ($urandom_range(4))
          0: return CMAX;
          1: return CMIN;
          2: return CMAX - $signed(32'($urandom_range(3)));
          3: return CMIN + $signed(32'($urandom_range(3)));
          default: return 0;
        endcase
      end
      default: return $signed($urandom);
    endcase
  endfunction

  // Mostly small grids so hits and endpoint touches are common
  function automatic si_seg_t rand_pair();
    si_seg_t r;
    int kind;
    logic signed [CW-1:0] org;
    int sel;
    sel  = $urandom_range(9);
    kind = sel < 5 ? 0 : sel < 8 ? 1 : sel < 9 ? 2 : 3;
    org  = $signed($urandom);
    r.func = 1'($urandom_range(1));
    r.ax = pick_coord(kind, org);
    r.ay = pick_coord(kind, org);
    r.bx = pick_coord(kind, org);
    r.by = pick_coord(kind, org);
    r.cx = pick_coord(kind, org);
    r.cy = pick_coord(kind, org);
    r.dx = pick_coord(kind, org);
    r.dy = pick_coord(kind, org);
    return r;
  endfunction

  // Offer one request, hold it until taken, queue its result
  task automatic send_req(si_seg_t r, bit known, seg_hit_t res);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func  = r.func;
    in_ch.ax = r.ax;
    in_ch.ay = r.ay;
    in_ch.bx = r.bx;
    in_ch.by = r.by;
    in_ch.cx = r.cx;
    in_ch.cy = r.cy;
    in_ch.dx = r.dx;
    in_ch.dy = r.dy;
    do @(posedge clk); while (!in_ch.ready);
    hit_q.push_back(known ? res : seg_cross(r));
    @(negedge clk);
  endtask

  // Receiver: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready = $urandom_range(99) >= rcv_idle_pct;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    seg_hit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b ix=%0d iy=%0d", $time,
                 out_ch.hit, out_ch.ix, out_ch.iy);
        errors++;
      end else begin
        want = hit_q.pop_front();
        if (out_ch.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.ix !== want.ix) begin
          $display("%0t: ix expected %0d actual %0d", $time, want.ix, out_ch.ix);
          errors++;
        end
        if (out_ch.iy !== want.iy) begin
          $display("%0t: iy expected %0d actual %0d", $time, want.iy, out_ch.iy);
          errors++;
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("segment_intersection test failed");
      $finish;
    end
  end

  initial begin
    seg_hit_t none;
    none = '0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    snd_idle_pct = 27;
    rcv_idle_pct = 76;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PLAIN;
    {in_ch.ax, in_ch.ay, in_ch.bx, in_ch.by} = '0;
    {in_ch.cx, in_ch.cy, in_ch.dx, in_ch.dy} = '0;

    // Directed pairs: parallel, collinear, crossings, endpoint touches, extremes
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 4, 0, 0, 1, 4, 1}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 4, 0, 2, 0, 6, 0}, 1, none});
    dir_tab.push_back('{'{FUNC_NO_ENDS, 0, 0, 4, 0, 2, 0, 6, 0}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 2, 2, 0, 2, 2, 0}, 1, '{1'b1, 65536, 65536}});
    dir_tab.push_back('{'{FUNC_NO_ENDS, 0, 0, 2, 2, 0, 2, 2, 0}, 1, '{1'b1, 65536, 65536}});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 2, 0, 2, 0, 2, 5}, 1, '{1'b1, 131072, 0}});
    dir_tab.push_back('{'{FUNC_NO_ENDS, 0, 0, 2, 0, 2, 0, 2, 5}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 4, 0, 1, -2, 1, 0}, 0, none});
    dir_tab.push_back('{'{FUNC_NO_ENDS, 0, 0, 4, 0, 1, -2, 1, 0}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 1, 1, 5, 0, 6, -3}, 0, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 3, 3, 3, 3, 0, 0, 6, 6}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 0, 0, 0, 0, 0, 0}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, 0, 0, 3, 1, 1, 0, 0, 1}, 0, none});
    dir_tab.push_back('{'{FUNC_PLAIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 0, none});
    dir_tab.push_back('{'{FUNC_NO_ENDS, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 0,
                       none});
    dir_tab.push_back('{'{FUNC_PLAIN, CMAX, 0, CMIN, 0, 0, CMAX, 0, CMIN}, 0, none});
    dir_tab.push_back('{'{FUNC_NO_ENDS, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 0,
                       none});
    dir_tab.push_back('{'{FUNC_PLAIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1, none});
    dir_tab.push_back('{'{FUNC_PLAIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX}, 0, none});

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].res);

    // Random requests over three idling phases
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        snd_idle_pct = 76;
        rcv_idle_pct = 27;
      end
      if (n == 2 * N_RANDOM / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_cycles = 400;
      end
      if (n == N_RANDOM / 6) begin
        in_ch.valid = 1'b0;
        while (hit_q.size() != 0) @(negedge clk);
      end
      send_req(rand_pair(), 0, none);
    end
    in_ch.valid = 1'b0;

    // Drain, then allow the pipeline depth for strays
    while (hit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("segment_intersection test passed");
    end else begin
      $display("segment_intersection test failed");
    end
    $finish;
  end
endmodule
